[hdl/morse_trie_codec_unit_macros.svh]
// Assertion macros of the morse trie codec RTL.
`ifndef MORSE_TRIE_CODEC_UNIT_MACROS_SVH
`define MORSE_TRIE_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("morse_trie_codec_unit: check failed");

// Next-cycle implication, disabled while reset is held.
`define MTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("morse_trie_codec_unit: check failed");

`endif

[hdl/mtc_pkg.sv]
// Types, codes and constants of the morse trie codec.
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

    // Default tree depth in code elements
    localparam int MAX_DEPTH_DEF = 7;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 7;
    localparam int LEN_W    = 3;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DECODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Characters
    localparam logic [CHAR_W-1:0] CHAR_QUERY   = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_CASE    = 8'h20;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_in;
        logic [CODE_W-1:0] code_in;
        logic [LEN_W-1:0]  code_len_in;
    } t_req;

    typedef struct packed {
        logic [CHAR_W-1:0]   char_out;
        logic [CODE_W-1:0]   code_out;
        logic [LEN_W-1:0]    code_len_out;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

`default_nettype wire

[hdl/morse_trie_codec_unit.sv]
// Top level of the morse trie codec: sequencer over the node memories.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------
//  request | in        | i_in_valid / o_in_ready   | i_in_data
//  result  | out       | o_out_valid / i_out_ready | o_out_data
//
// After reset a clearing pass walks all 2^(MAX_DEPTH+1)-1 nodes, one per cycle;
// no request is taken meanwhile.
// Encode visits the nodes with one read of the node memories per cycle.
// A finished result waits in the output register while the next request runs.
`timescale 1ns / 1ps
`default_nettype none

module morse_trie_codec_unit
    import mtc_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output      logic o_in_ready,
    input  wire t_req i_in_data,
    output      logic o_out_valid,
    input  wire logic i_out_ready,
    output      t_rsp o_out_data
);

`include "morse_trie_codec_unit_macros.svh"

    localparam int NODE_COUNT = (1 << (MAX_DEPTH + 1)) - 1;
    localparam int AW         = $clog2(NODE_COUNT);
    localparam int DW         = $clog2(MAX_DEPTH + 1);
    localparam int EXT_W      = MAX_DEPTH + CODE_W;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_RES  = 3'd5;

    // Heap index of the node at the end of a path: 2^d - 1 plus the path bits,
    // first element as most significant bit.
    function automatic logic [AW-1:0] idx_of(input logic [MAX_DEPTH-1:0] p,
                                             input logic [DW-1:0] d);
        logic [AW-1:0] acc;
        acc = '0;
        for (int j = 0; j < MAX_DEPTH; j++) begin
            if (j < int'(d)) begin
                acc = {acc[AW-2:0], p[j]};
            end
        end
        return acc + ((AW'(1) << d) - AW'(1));
    endfunction

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_idx, n_idx;
    logic [MAX_DEPTH-1:0] r_path, n_path;
    logic [DW-1:0]        r_depth, n_depth;
    logic [DW-1:0]        r_len, n_len;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_tree, n_tree;
    t_rsp                 r_res, n_res;
    logic                 r_ov, n_ov;
    t_rsp                 r_out, n_out;

    logic                 we_vld, we_chr;
    logic [AW-1:0]        waddr;
    logic                 wdata_vld;
    logic [CHAR_W-1:0]    wdata_chr;
    logic                 rd_vld;
    logic [CHAR_W-1:0]    rd_chr;

    logic [EXT_W-1:0]     code_ext;
    logic [EXT_W-1:0]     path_ext;
    logic [DW-1:0]        len_clamp;
    logic [CHAR_W-1:0]    char_up;
    logic                 hit;
    logic                 skip_found;
    logic [DW-1:0]        skip_k;
    logic [MAX_DEPTH-1:0] skip_path;
    logic                 out_free;

    // Node exists flags
    mtc_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (we_vld),
        .i_waddr (waddr),
        .i_wdata (wdata_vld),
        .i_raddr (n_idx),
        .o_rdata (rd_vld)
    );

    // Node characters
    mtc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (NODE_COUNT)
    ) u_chr_ram (
        .i_clk   (i_clk),
        .i_we    (we_chr),
        .i_waddr (waddr),
        .i_wdata (wdata_chr),
        .i_raddr (n_idx),
        .o_rdata (rd_chr)
    );

    // Decode request fields
    always_comb begin
        code_ext = EXT_W'(i_in_data.code_in);
        if (int'(i_in_data.code_len_in) > MAX_DEPTH) begin
            len_clamp = DW'(MAX_DEPTH);
        end else begin
            len_clamp = DW'(i_in_data.code_len_in);
        end
        if (i_in_data.char_in >= CHAR_LOWER_A && i_in_data.char_in <= CHAR_LOWER_Z) begin
            char_up = i_in_data.char_in - CHAR_CASE;
        end else begin
            char_up = i_in_data.char_in;
        end
    end

    // Find the next preorder node past the current subtree:
    // deepest dot element on the path turns into a dash.
    always_comb begin
        skip_found = 1'b0;
        skip_k     = '0;
        for (int j = 0; j < MAX_DEPTH; j++) begin
            if (j < int'(r_depth) && !r_path[j]) begin
                skip_found = 1'b1;
                skip_k     = DW'(j);
            end
        end
        for (int j = 0; j < MAX_DEPTH; j++) begin
            if (j < int'(skip_k)) begin
                skip_path[j] = r_path[j];
            end else begin
                skip_path[j] = (j == int'(skip_k));
            end
        end
    end

    assign hit      = rd_vld && (rd_chr == r_char);
    assign path_ext = EXT_W'(r_path);
    assign out_free = !r_ov || i_out_ready;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_path    = r_path;
        n_depth   = r_depth;
        n_len     = r_len;
        n_char    = r_char;
        n_tree    = r_tree;
        n_res     = r_res;
        n_ov      = r_ov && !i_out_ready;
        n_out     = r_out;
        we_vld    = 1'b0;
        we_chr    = 1'b0;
        waddr     = r_idx;
        wdata_vld = 1'b0;
        wdata_chr = '0;

        case (r_state)
            // Clear both memories one node a cycle
            ST_CLR: begin
                we_vld = 1'b1;
                we_chr = 1'b1;
                if (r_idx == AW'(NODE_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end

            // Take a transaction and start its walk
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_len   = len_clamp;
                    n_path  = code_ext[MAX_DEPTH-1:0];
                    n_depth = '0;
                    case (i_in_data.req_type)
                        REQ_INSERT: begin
                            n_char  = i_in_data.char_in;
                            n_tree  = 1'b1;
                            n_state = ST_INS;
                        end
                        REQ_DECODE: begin
                            if (!r_tree) begin
                                n_res.char_out = CHAR_QUERY;
                                n_res.status   = STAT_EMPTY;
                                n_state        = ST_RES;
                            end else begin
                                n_idx   = idx_of(code_ext[MAX_DEPTH-1:0], len_clamp);
                                n_state = ST_DEC;
                            end
                        end
                        REQ_ENCODE: begin
                            n_char = char_up;
                            // Start the scan at the root with an all-dot path
                            n_path = '0;
                            if (!r_tree) begin
                                n_res.status = STAT_EMPTY;
                                n_state      = ST_RES;
                            end else begin
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = ST_RES;
                        end
                    endcase
                end
            end

            // Mark each node on the path, store the character at its end
            ST_INS: begin
                we_vld    = 1'b1;
                wdata_vld = 1'b1;
                waddr     = idx_of(r_path, r_depth);
                wdata_chr = r_char;
                if (r_depth == r_len) begin
                    we_chr  = 1'b1;
                    n_state = ST_RES;
                end else begin
                    n_depth = r_depth + DW'(1);
                end
            end

            // Read back the addressed node
            ST_DEC: begin
                n_res.char_out = rd_vld ? rd_chr : '0;
                n_state        = ST_RES;
            end

            // Dot-first preorder scan, one node per cycle
            ST_SCAN: begin
                if (hit) begin
                    n_res.code_out     = path_ext[CODE_W-1:0];
                    n_res.code_len_out = LEN_W'(r_depth);
                    n_res.status       = STAT_DONE;
                    n_state            = ST_RES;
                end else if (rd_vld && int'(r_depth) < MAX_DEPTH) begin
                    n_depth = r_depth + DW'(1);
                    n_idx   = idx_of(r_path, r_depth + DW'(1));
                end else if (skip_found) begin
                    n_path  = skip_path;
                    n_depth = skip_k + DW'(1);
                    n_idx   = idx_of(skip_path, skip_k + DW'(1));
                end else begin
                    n_res.status = STAT_NOT_FOUND;
                    n_state      = ST_RES;
                end
            end

            // Hand the result to the output register once it is free
            ST_RES: begin
                if (out_free) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_idx   <= '0;
            r_tree  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_tree  <= n_tree;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_path  <= n_path;
        r_depth <= n_depth;
        r_len   <= n_len;
        r_char  <= n_char;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Checks
    `MTC_ASSERT_IMP(a_clr_tree_empty, i_clk, i_rst_n, r_state == ST_CLR, !r_tree)
    `MTC_ASSERT_IMP(a_scan_depth, i_clk, i_rst_n, r_state == ST_SCAN, int'(r_depth) <= MAX_DEPTH)
    `MTC_ASSERT_IMP(a_out_from_res, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == ST_RES)
    `MTC_ASSERT_IMP(a_notfound_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status == STAT_NOT_FOUND, o_out_data.code_out == '0 && o_out_data.code_len_out == '0)
    `MTC_ASSERT_NXT(a_ins_ends, i_clk, i_rst_n, r_state == ST_INS && r_depth == r_len, r_state == ST_RES)

endmodule

`default_nettype wire

[hdl/mtc_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 255
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[dv/mtc_checker.sv]
`timescale 1ns / 1ps
// Result checker of the morse trie codec: watches both channels, predicts, compares.
module mtc_checker
    import mtc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_rsp i_out_data,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int DEPTH = MAX_DEPTH_DEF;
    localparam int NODES = 2 ** (DEPTH + 1) - 1;

    // Shadow copy of the tree: heap order, dot child 2i+1, dash child 2i+2
    logic [CHAR_W-1:0] node_char [NODES];
    bit                node_live [NODES];
    bit                tree_loaded;

    t_rsp expected_rsp [$];
    int   mismatch_count;

    // Turn a heap slot back into its code and depth
    function automatic void heap_path(input int slot, output int path, output int depth);
        int i;
        i = slot;
        path = 0;
        depth = 0;
        // Climbing yields the last element first, so shift it up; the first element ends in bit 0
        while (i > 0) begin
            path = (path << 1) | ((i % 2 == 0) ? 1 : 0);
            i = (i - 1) / 2;
            depth++;
        end
    endfunction

    // Dot-first preorder search over existing nodes
    function automatic bit find_char(input logic [CHAR_W-1:0] ch,
                                     output logic [CODE_W-1:0] code,
                                     output logic [LEN_W-1:0] len);
        int stk [32];
        int sp;
        int slot;
        int path;
        int depth;
        bit hit;
        hit = 1'b0;
        code = '0;
        len = '0;
        stk[0] = 0;
        sp = 1;
        while (sp > 0 && !hit) begin
            sp--;
            slot = stk[sp];
            if (slot < NODES && node_live[slot]) begin
                heap_path(slot, path, depth);
                if (node_char[slot] == ch) begin
                    hit = 1'b1;
                    code = path[CODE_W-1:0];
                    len = depth[LEN_W-1:0];
                end else if (depth < DEPTH) begin
                    // Push dash first so the dot subtree pops first
                    stk[sp] = 2 * slot + 2;
                    stk[sp + 1] = 2 * slot + 1;
                    sp += 2;
                end
            end
        end
        return hit;
    endfunction

    // Apply one request to the shadow tree and return its result
    function automatic t_rsp trie_response(input t_req req);
        t_rsp              rsp;
        int                slot;
        int                steps;
        int                d;
        logic [CHAR_W-1:0] key;
        logic [CODE_W-1:0] hit_code;
        logic [LEN_W-1:0]  hit_len;
        rsp = '0;
        steps = (req.code_len_in > DEPTH) ? DEPTH : int'(req.code_len_in);
        slot = 0;
        // Walk the code; an insert creates every node on the way
        if (req.req_type == REQ_INSERT)
            node_live[0] = 1'b1;
        for (d = 0; d < steps; d++) begin
            slot = 2 * slot + 1 + int'(req.code_in[d]);
            if (req.req_type == REQ_INSERT)
                node_live[slot] = 1'b1;
        end
        case (req.req_type)
            REQ_INSERT: begin
                node_char[slot] = req.char_in;
                tree_loaded = 1'b1;
            end
            REQ_DECODE: begin
                if (!tree_loaded) begin
                    rsp.char_out = CHAR_QUERY;
                    rsp.status = STAT_EMPTY;
                end else begin
                    rsp.char_out = node_live[slot] ? node_char[slot] : '0;
                end
            end
            REQ_ENCODE: begin
                if (!tree_loaded) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    key = req.char_in;
                    if (key >= CHAR_LOWER_A && key <= CHAR_LOWER_Z)
                        key = key - CHAR_CASE;
                    if (find_char(key, hit_code, hit_len)) begin
                        rsp.code_out = hit_code;
                        rsp.code_len_out = hit_len;
                    end else begin
                        rsp.status = STAT_NOT_FOUND;
                    end
                end
            end
            default: begin
                // Unused request: no state change, all-zero result
            end
        endcase
        return rsp;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on each request transaction, compare on each result transaction
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            foreach (node_char[n]) begin
                node_char[n] = '0;
                node_live[n] = 1'b0;
            end
            tree_loaded = 1'b0;
            expected_rsp.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_rsp.push_back(trie_response(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("result transaction 0x%0h with no request waiting", i_out_data);
                    mismatch_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    check_field("char_out", want.char_out, i_out_data.char_out);
                    check_field("code_out", CHAR_W'(want.code_out),
                                CHAR_W'(i_out_data.code_out));
                    check_field("code_len_out", CHAR_W'(want.code_len_out),
                                CHAR_W'(i_out_data.code_len_out));
                    check_field("status", CHAR_W'(want.status),
                                CHAR_W'(i_out_data.status));
                end
            end
        end
        o_outstanding <= expected_rsp.size();
        o_mismatches <= mismatch_count;
    end

endmodule

[dv/tb_morse_trie_codec_unit.sv]
`timescale 1ns / 1ps
// Testbench top of the morse trie codec: stimulus, handshake idling and verdict.
module tb_morse_trie_codec_unit;
    import mtc_pkg::*;

    localparam logic [REQ_W-1:0]  REQ_UNUSED       = 2'd3;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A     = 8'h41;
    localparam int                RANDOM_ITEMS     = 1250;
    localparam int                SINK_HOLD_CYCLES = 700;
    localparam int                STALL_LIMIT      = 5000;
    localparam int                TAIL_CYCLES      = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    t_req req_data;
    logic rsp_valid;
    logic rsp_ready;
    t_rsp rsp_data;

    int mismatches;
    int outstanding;
    int stall_cycles;
    bit calm;
    int sink_holds_asked;
    int sink_holds_done;

    // Paths and characters inserted so far, to aim decodes and encodes at real nodes
    logic [CODE_W-1:0] known_code [$];
    logic [LEN_W-1:0]  known_len [$];
    logic [CHAR_W-1:0] known_char [$];

    always #2 clk = ~clk;

    morse_trie_codec_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (rsp_data)
    );

    mtc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .i_in_ready    (req_ready),
        .i_in_data     (req_data),
        .i_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .i_out_data    (rsp_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 90);
    endfunction

    // Letters of both cases, known characters, zero and any byte
    function automatic logic [CHAR_W-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25));
        if (roll < 55)
            return CHAR_LOWER_A + CHAR_W'($urandom_range(0, 25));
        if (roll < 70 && known_char.size() > 0)
            return known_char[$urandom_range(0, known_char.size() - 1)];
        if (roll < 75)
            return '0;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Offer one request and hold it until the transaction completes
    task automatic offer(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                         input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        t_req item;
        int   gap;
        item.req_type = kind;
        item.char_in = ch;
        item.code_in = code;
        item.code_len_in = len;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= item;
        do @(posedge clk); while (!req_ready);
        if (kind == REQ_INSERT) begin
            known_code.push_back(code);
            known_len.push_back(len);
            known_char.push_back(ch);
        end
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random ready pattern plus requested long hold-offs
    initial begin : result_sink
        int gap;
        int run;
        rsp_ready = 1'b0;
        forever begin
            if (sink_holds_asked != sink_holds_done) begin
                sink_holds_done++;
                rsp_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            run = calm ? 64 : $urandom_range(1, 24);
            repeat (run) @(posedge clk);
        end
    end

    initial begin : stimulus
        int                k;
        int                roll;
        int                pick;
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] ch;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] mask;
        logic [LEN_W-1:0]  len;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        calm = 1'b0;
        sink_holds_asked = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty tree answers, unused request type
        offer(REQ_DECODE, 8'h00, 7'h00, 3'd0);
        offer(REQ_ENCODE, 8'h45, 7'h00, 3'd0);
        offer(REQ_UNUSED, 8'hFF, 7'h7F, 3'd7);
        offer(REQ_DECODE, 8'hFF, 7'h7F, 3'd7);
        // Build a few nodes, including both deepest corners
        offer(REQ_INSERT, 8'h45, 7'h00, 3'd1);
        offer(REQ_INSERT, 8'h54, 7'h01, 3'd1);
        offer(REQ_INSERT, 8'hFF, 7'h7F, 3'd7);
        offer(REQ_INSERT, 8'h80, 7'h00, 3'd7);
        // Decode: deepest node, root without a character, missing node, empty node
        offer(REQ_DECODE, 8'h00, 7'h7F, 3'd7);
        offer(REQ_DECODE, 8'h00, 7'h00, 3'd0);
        offer(REQ_DECODE, 8'h00, 7'h55, 3'd5);
        offer(REQ_DECODE, 8'h00, 7'h00, 3'd3);
        // Encode: lower case hit, miss, zero byte matching the root
        offer(REQ_ENCODE, 8'h65, 7'h00, 3'd0);
        offer(REQ_ENCODE, 8'h7A, 7'h00, 3'd0);
        offer(REQ_ENCODE, 8'h00, 7'h00, 3'd0);
        // Fill the root, then zero byte finds the first empty node
        offer(REQ_INSERT, 8'h41, 7'h2A, 3'd0);
        offer(REQ_ENCODE, 8'h00, 7'h00, 3'd0);
        offer(REQ_ENCODE, 8'h80, 7'h00, 3'd0);
        offer(REQ_ENCODE, 8'hFF, 7'h00, 3'd0);
        // Stored lower case is never matched; bytes just outside a..z stay as is
        offer(REQ_INSERT, 8'h61, 7'h05, 3'd3);
        offer(REQ_ENCODE, 8'h61, 7'h00, 3'd0);
        offer(REQ_ENCODE, 8'h60, 7'h00, 3'd0);
        offer(REQ_ENCODE, 8'h7B, 7'h00, 3'd0);
        // Overwrite a node and read it back
        offer(REQ_INSERT, 8'h49, 7'h00, 3'd1);
        offer(REQ_DECODE, 8'h00, 7'h00, 3'd1);
        offer(REQ_UNUSED, 8'h00, 7'h00, 3'd0);
        wait_for_results();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            // Phases: back-to-back stretch, long result hold-off, full drain
            if (k == 300)
                calm = 1'b1;
            if (k == 450)
                calm = 1'b0;
            if (k == 600)
                sink_holds_asked++;
            if (k == 800)
                wait_for_results();
            roll = $urandom_range(0, 99);
            ch = pick_char();
            code = CODE_W'($urandom_range(0, 127));
            len = LEN_W'($urandom_range(0, 7));
            if (roll < 4) begin
                kind = REQ_UNUSED;
            end else if (roll < 30) begin
                kind = REQ_INSERT;
            end else if (roll < 62) begin
                kind = REQ_DECODE;
                // Aim most decodes at an inserted path or one of its prefixes
                if (known_len.size() > 0 && $urandom_range(0, 99) < 60) begin
                    pick = $urandom_range(0, known_len.size() - 1);
                    len = LEN_W'($urandom_range(0, known_len[pick]));
                    mask = (7'd1 << len) - 7'd1;
                    code = (known_code[pick] & mask) | (code & ~mask);
                end
            end else begin
                kind = REQ_ENCODE;
            end
            offer(kind, ch, code, len);
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
